// File: src/ffm_pkg.sv
// Shared types and constants for the flow field moments block.
// No dependencies; used by every module in src but ffm_checker.
package ffm_pkg;

	localparam int unsigned TALLY_W = 21;
	localparam int unsigned RSUM_W  = 30;
	localparam int unsigned GSUM_W  = 37;
	localparam int unsigned PSUM_W  = 54;
	localparam int unsigned DIV_W   = 54;
	localparam int unsigned DCNT_W  = 6;
	localparam logic [TALLY_W-1:0] MAX_TALLY = 21'd1048576;

	localparam logic CMD_CENTROID = 1'b0;
	localparam logic CMD_MOTION   = 1'b1;

	// classified pixel handed from front to back
	typedef struct packed {
		logic        cmd;
		logic        counted;
		logic        last;
		logic [9:0]  row;
		logic [9:0]  col;
		logic signed [15:0] grad_x;
		logic signed [15:0] grad_y;
	} pix_t;

	typedef enum logic [4:0] {
		ST_ACC  = 5'b00001,
		ST_PROD = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_NEXT = 5'b01000,
		ST_OUT  = 5'b10000
	} back_state_t;

endpackage

// File: src/ffm_front.sv
// Front end: accept pixels, classify them against threshold and frame, queue them.
// Depends on ffm_pkg.
module ffm_front #(
	parameter int unsigned FRAME_ROWS = 1024,
	parameter int unsigned FRAME_COLS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_in,
	output logic                ready_out,
	input  logic                cmd,
	input  logic [9:0]          row,
	input  logic [9:0]          col,
	input  logic [15:0]         pixel_time,
	input  logic signed [15:0]  grad_x,
	input  logic signed [15:0]  grad_y,
	input  logic                last,
	input  logic [15:0]         threshold,
	output logic                q_valid,
	input  logic                q_pop,
	output ffm_pkg::pix_t       q_head
);
	ffm_pkg::pix_t fifo_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	ffm_pkg::pix_t pix;
	logic push;

	// classify the incoming pixel; 13 bits hold frame sizes up to 8191
	always_comb begin
		pix.cmd = cmd;
		pix.last = last;
		pix.row = row;
		pix.col = col;
		pix.grad_x = grad_x;
		pix.grad_y = grad_y;
		pix.counted = (pixel_time > threshold) && ({3'b0, row} < 13'(FRAME_ROWS))
			&& ({3'b0, col} < 13'(FRAME_COLS));
	end

	assign ready_out = (cnt_q != 3'd4);
	assign push = valid_in && ready_out;
	assign q_valid = (cnt_q != 3'd0);
	assign q_head = fifo_q[rd_q];

	// store queued pixels
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= pix;
	end

	// advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (q_pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(q_pop);
		end
	end
endmodule

// File: src/ffm_div.sv
// Restoring divider, one quotient bit per cycle, signed dividend, positive divisor.
// Depends on ffm_pkg.
module ffm_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [ffm_pkg::DIV_W-1:0]  dividend,
	input  logic [ffm_pkg::TALLY_W-1:0]       divisor,
	output logic                              done,
	output logic signed [ffm_pkg::DIV_W-1:0]  quotient
);
	localparam int unsigned W = ffm_pkg::DIV_W;
	localparam int unsigned CW = $clog2(W + 1);
	logic [W-1:0] num_q;
	logic [W-1:0] quo_q;
	logic [ffm_pkg::TALLY_W:0] rem_q;
	logic [ffm_pkg::TALLY_W-1:0] den_q;
	logic neg_q, busy_q;
	logic [CW-1:0] cnt_q;
	logic [ffm_pkg::TALLY_W+1:0] trial;
	logic [ffm_pkg::TALLY_W:0] shifted;

	assign shifted = {rem_q[ffm_pkg::TALLY_W-1:0], num_q[W-1]};
	assign trial = {1'b0, shifted} - {2'b0, den_q};
	assign done = busy_q && (cnt_q == '0);
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

	// one shift-subtract step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(W);
		end else if (busy_q) begin
			if (cnt_q == '0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[W-1];
			num_q <= dividend[W-1] ? W'(-dividend) : W'(dividend);
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			num_q <= {num_q[W-2:0], 1'b0};
			if (!trial[ffm_pkg::TALLY_W+1]) begin
				rem_q <= trial[ffm_pkg::TALLY_W:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end
endmodule

// File: src/ffm_back.sv
// Back end: accumulate moments, divide at pass end, hold the result register.
// Depends on ffm_pkg and ffm_div.
module ffm_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_pop,
	input  ffm_pkg::pix_t              q_head,
	output logic                       valid_out,
	input  logic                       ready_in,
	output logic                       kind,
	output logic                       status,
	output logic [20:0]                count,
	output logic [15:0]                center_row,
	output logic [15:0]                center_col,
	output logic signed [15:0]         mean_grad_x,
	output logic signed [15:0]         mean_grad_y,
	output logic signed [33:0]         rotation,
	output logic signed [33:0]         divergence
);
	localparam int unsigned DW = ffm_pkg::DIV_W;
	ffm_pkg::back_state_t st_q;
	logic [15:0] cen_row_q, cen_col_q;
	logic [ffm_pkg::TALLY_W-1:0] tally_q;
	logic [ffm_pkg::RSUM_W-1:0] rsum_q, csum_q;
	logic signed [ffm_pkg::GSUM_W-1:0] gxs_q, gys_q;
	logic signed [ffm_pkg::PSUM_W-1:0] xs_q, ds_q;
	// product stage
	logic signed [32:0] p_ry_s1, p_cx_s1, p_rx_s1, p_cy_s1;
	logic signed [16:0] dr, dc;
	ffm_pkg::pix_t pix_q;
	logic [2:0] dsel_q;
	logic div_start;
	logic signed [DW-1:0] div_num, div_quo;
	logic div_done;
	logic res_cmd_q;
	logic cnt_ok;

	assign dr = $signed({1'b0, q_head.row, 6'b0}) - $signed({1'b0, cen_row_q});
	assign dc = $signed({1'b0, q_head.col, 6'b0}) - $signed({1'b0, cen_col_q});
	// hold a last pixel in the queue while a result still waits
	assign q_pop = q_valid && (st_q == ffm_pkg::ST_ACC) && !(q_head.last && valid_out);
	assign cnt_ok = pix_q.counted && (tally_q < ffm_pkg::MAX_TALLY);

	// pick the next dividend; position sums are unsigned
	always_comb begin
		case (dsel_q)
			3'd0: div_num = DW'({rsum_q, 6'b0});
			3'd1: div_num = DW'({csum_q, 6'b0});
			3'd2: div_num = DW'(gxs_q);
			3'd3: div_num = DW'(gys_q);
			3'd4: div_num = xs_q;
			default: div_num = ds_q;
		endcase
	end
	assign div_start = (st_q == ffm_pkg::ST_NEXT);

	ffm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(tally_q), .done(div_done), .quotient(div_quo)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pix_q <= q_head;
			p_ry_s1 <= dr * q_head.grad_y;
			p_cx_s1 <= dc * q_head.grad_x;
			p_rx_s1 <= dr * q_head.grad_x;
			p_cy_s1 <= dc * q_head.grad_y;
		end
	end

	// sequence accumulate, divide and emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ffm_pkg::ST_ACC;
			valid_out <= 1'b0;
			cen_row_q <= '0; cen_col_q <= '0;
			tally_q <= '0; rsum_q <= '0; csum_q <= '0;
			gxs_q <= '0; gys_q <= '0; xs_q <= '0; ds_q <= '0;
			dsel_q <= '0; res_cmd_q <= 1'b0;
			kind <= 1'b0; status <= 1'b0; count <= '0;
			center_row <= '0; center_col <= '0;
			mean_grad_x <= '0; mean_grad_y <= '0; rotation <= '0; divergence <= '0;
		end else begin
			// raise valid on a new result, drop it after the transfer
			if (st_q == ffm_pkg::ST_OUT && (!valid_out || ready_in)) valid_out <= 1'b1;
			else if (valid_out && ready_in) valid_out <= 1'b0;
			case (st_q)
				ffm_pkg::ST_ACC: if (q_pop) st_q <= ffm_pkg::ST_PROD;
				ffm_pkg::ST_PROD: begin
					logic [ffm_pkg::TALLY_W-1:0] nt;
					nt = tally_q + ffm_pkg::TALLY_W'(cnt_ok);
					tally_q <= nt;
					if (cnt_ok) begin
						if (pix_q.cmd == ffm_pkg::CMD_CENTROID) begin
							rsum_q <= rsum_q + ffm_pkg::RSUM_W'(pix_q.row);
							csum_q <= csum_q + ffm_pkg::RSUM_W'(pix_q.col);
						end else begin
							gxs_q <= gxs_q + ffm_pkg::GSUM_W'(pix_q.grad_x);
							gys_q <= gys_q + ffm_pkg::GSUM_W'(pix_q.grad_y);
							xs_q <= xs_q + ffm_pkg::PSUM_W'(p_ry_s1)
								- ffm_pkg::PSUM_W'(p_cx_s1);
							ds_q <= ds_q + ffm_pkg::PSUM_W'(p_rx_s1)
								+ ffm_pkg::PSUM_W'(p_cy_s1);
						end
					end
					if (!pix_q.last) st_q <= ffm_pkg::ST_ACC;
					else begin
						res_cmd_q <= pix_q.cmd;
						kind <= pix_q.cmd;
						count <= nt;
						status <= (nt == '0);
						center_row <= '0; center_col <= '0;
						mean_grad_x <= '0; mean_grad_y <= '0;
						rotation <= '0; divergence <= '0;
						dsel_q <= (pix_q.cmd == ffm_pkg::CMD_CENTROID) ? 3'd0 : 3'd2;
						st_q <= (nt == '0) ? ffm_pkg::ST_OUT : ffm_pkg::ST_NEXT;
					end
				end
				ffm_pkg::ST_NEXT: st_q <= ffm_pkg::ST_DIV;
				ffm_pkg::ST_DIV: if (div_done) begin
					case (dsel_q)
						3'd0: center_row <= div_quo[15:0];
						3'd1: center_col <= div_quo[15:0];
						3'd2: mean_grad_x <= div_quo[15:0];
						3'd3: mean_grad_y <= div_quo[15:0];
						3'd4: rotation <= div_quo[33:0];
						default: divergence <= div_quo[33:0];
					endcase
					dsel_q <= dsel_q + 3'd1;
					if (dsel_q == 3'd1 || dsel_q == 3'd5) st_q <= ffm_pkg::ST_OUT;
					else st_q <= ffm_pkg::ST_NEXT;
				end
				ffm_pkg::ST_OUT: if (!valid_out || ready_in) begin
					if (res_cmd_q == ffm_pkg::CMD_CENTROID && !status) begin
						cen_row_q <= center_row;
						cen_col_q <= center_col;
					end
					tally_q <= '0; rsum_q <= '0; csum_q <= '0;
					gxs_q <= '0; gys_q <= '0; xs_q <= '0; ds_q <= '0;
					st_q <= ffm_pkg::ST_ACC;
				end
				default: st_q <= ffm_pkg::ST_ACC;
			endcase
		end
	end
endmodule

// File: src/flow_field_moments_top.sv
// Top level of the flow field moments block: front classifier, queue, back end.
// Depends on ffm_pkg, ffm_front, ffm_back.
//
// channel   | handshake             | payload
// pixel in  | valid_in / ready_out  | cmd row col pixel_time grad_x grad_y last
// result    | valid_out / ready_in  | kind status count center_* mean_* rotation divergence
// config    | cfg_we                | cfg_data (occupancy threshold)
//
// In the back end a pixel is registered with its products, then accumulated; the next
// pixel is taken only after that. A last pixel adds a divide per quotient: 2 for a
// centroid pass, 4 for a motion pass, run on one shared bit-serial divider. The 4-entry
// queue takes pixels until it is full while the back end divides or the result waits;
// a last pixel stays at the queue head until the held result is transferred. Reset
// is asynchronous and clears all sums and the centroid.
module flow_field_moments_top #(
	parameter int unsigned FRAME_ROWS = 1024,
	parameter int unsigned FRAME_COLS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_data,
	input  logic               valid_in,
	output logic               ready_out,
	input  logic               cmd,
	input  logic [9:0]         row,
	input  logic [9:0]         col,
	input  logic [15:0]        pixel_time,
	input  logic signed [15:0] grad_x,
	input  logic signed [15:0] grad_y,
	input  logic               last,
	output logic               valid_out,
	input  logic               ready_in,
	output logic               kind,
	output logic               status,
	output logic [20:0]        count,
	output logic [15:0]        center_row,
	output logic [15:0]        center_col,
	output logic signed [15:0] mean_grad_x,
	output logic signed [15:0] mean_grad_y,
	output logic signed [33:0] rotation,
	output logic signed [33:0] divergence
);
	logic [15:0] thr_q;
	logic q_valid, q_pop;
	ffm_pkg::pix_t q_head;

	// hold the threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= '0;
		else if (cfg_we) thr_q <= cfg_data;
	end

	ffm_front #(.FRAME_ROWS(FRAME_ROWS), .FRAME_COLS(FRAME_COLS)) u_front (
		.clk(clk), .arst_n(arst_n), .valid_in(valid_in), .ready_out(ready_out),
		.cmd(cmd), .row(row), .col(col), .pixel_time(pixel_time),
		.grad_x(grad_x), .grad_y(grad_y), .last(last), .threshold(thr_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
	);

	ffm_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
		.valid_out(valid_out), .ready_in(ready_in), .kind(kind), .status(status),
		.count(count), .center_row(center_row), .center_col(center_col),
		.mean_grad_x(mean_grad_x), .mean_grad_y(mean_grad_y),
		.rotation(rotation), .divergence(divergence)
	);
endmodule

// File: src/ffm_checker.sv
// Port-level checker for flow_field_moments_top, bound to the top level.
// Depends on flow_field_moments_top ports only.
module ffm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid_out,
	input logic        ready_in,
	input logic        status,
	input logic [20:0] count,
	input logic [15:0] center_row,
	input logic [33:0] rotation
);
	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && !ready_in |=> valid_out && $stable(count))
		else $error("result dropped while stalled");
	// empty pass reports zero count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && status |-> count == 21'd0)
		else $error("empty pass with nonzero count");
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && !status |-> count != 21'd0)
		else $error("ok status with zero count");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && status |-> center_row == 16'd0 && rotation == 34'd0)
		else $error("empty pass with nonzero fields");
endmodule

bind flow_field_moments_top ffm_checker u_ffm_checker (
	.clk(clk), .arst_n(arst_n), .valid_out(valid_out), .ready_in(ready_in),
	.status(status), .count(count), .center_row(center_row), .rotation(rotation)
);

// File: dv/flow_field_moments_top_test.sv
// Self-checking testbench for flow_field_moments_top: centroid and motion passes over
// a pixel stream with random stalls on both channels. Depends on ffm_pkg and the RTL.
module flow_field_moments_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ROWS = 1024;
	localparam int unsigned COLS = 1024;
	localparam longint TALLY_CAP = 1048576;
	localparam int unsigned ITEM_TARGET = 1950;
	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned SETTLE_CYCLES = 300;

	typedef struct {
		logic        cmd;
		logic [9:0]  row;
		logic [9:0]  col;
		logic [15:0] ptime;
		logic [15:0] gx;
		logic [15:0] gy;
		logic        last;
	} pixel_t;

	typedef struct {
		logic        kind;
		logic        status;
		longint      count;
		longint      crow;
		longint      ccol;
		longint      mgx;
		longint      mgy;
		longint      rot;
		longint      dvg;
	} moments_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_data = '0;
	logic valid_in = 1'b0;
	logic ready_out;
	logic cmd = 1'b0;
	logic [9:0] row = '0;
	logic [9:0] col = '0;
	logic [15:0] pixel_time = '0;
	logic signed [15:0] grad_x = '0;
	logic signed [15:0] grad_y = '0;
	logic last = 1'b0;
	logic valid_out;
	logic ready_in = 1'b0;
	logic kind;
	logic status;
	logic [20:0] count;
	logic [15:0] center_row;
	logic [15:0] center_col;
	logic signed [15:0] mean_grad_x;
	logic signed [15:0] mean_grad_y;
	logic signed [33:0] rotation;
	logic signed [33:0] divergence;

	flow_field_moments_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.valid_in(valid_in), .ready_out(ready_out), .cmd(cmd), .row(row), .col(col),
		.pixel_time(pixel_time), .grad_x(grad_x), .grad_y(grad_y), .last(last),
		.valid_out(valid_out), .ready_in(ready_in), .kind(kind), .status(status),
		.count(count), .center_row(center_row), .center_col(center_col),
		.mean_grad_x(mean_grad_x), .mean_grad_y(mean_grad_y),
		.rotation(rotation), .divergence(divergence)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	pixel_t pixel_q[$];
	moments_t moments_q[$];
	pixel_t cur_pixel;
	int unsigned items_sent = 0;
	int unsigned errors = 0;
	bit quiet_mode = 0;

	// shadow of the block state
	logic [15:0] thr_shadow = '0;
	longint cen_row = 0, cen_col = 0, tally = 0;
	longint rsum = 0, csum = 0, gxsum = 0, gysum = 0, xsum = 0, dsum = 0;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet_mode || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// update sums for one transferred pixel; queue a result on the last one
	task automatic predict_moments(input pixel_t p);
		moments_t m;
		longint dr, dc, gx, gy;
		gx = longint'($signed(p.gx));
		gy = longint'($signed(p.gy));
		if (p.ptime > thr_shadow && p.row < ROWS && p.col < COLS && tally < TALLY_CAP) begin
			tally++;
			if (p.cmd == ffm_pkg::CMD_CENTROID) begin
				rsum += p.row;
				csum += p.col;
			end else begin
				dr = longint'(p.row) * 64 - cen_row;
				dc = longint'(p.col) * 64 - cen_col;
				gxsum += gx;
				gysum += gy;
				xsum += dr * gy - dc * gx;
				dsum += dr * gx + dc * gy;
			end
		end
		if (!p.last)
			return;
		m = '{p.cmd, 1'b0, tally, 0, 0, 0, 0, 0, 0};
		if (tally == 0) begin
			m.status = 1'b1;
		end else if (p.cmd == ffm_pkg::CMD_CENTROID) begin
			cen_row = ((rsum * 64) / tally) & 16'hFFFF;
			cen_col = ((csum * 64) / tally) & 16'hFFFF;
			m.crow = cen_row;
			m.ccol = cen_col;
		end else begin
			m.mgx = gxsum / tally;
			m.mgy = gysum / tally;
			m.rot = xsum / tally;
			m.dvg = dsum / tally;
		end
		moments_q.push_back(m);
		tally = 0; rsum = 0; csum = 0; gxsum = 0; gysum = 0; xsum = 0; dsum = 0;
	endtask

	// driver: hold the current pixel until its transfer, then insert a gap
	int unsigned in_gap = 0;
	always @(posedge clk) begin : pixel_driver
		logic nv;
		nv = valid_in;
		if (valid_in && ready_out)
			predict_moments(cur_pixel);
		if (!valid_in || ready_out) begin
			nv = 1'b0;
			if (in_gap > 0) begin
				in_gap--;
			end else if (arst_n && pixel_q.size() > 0) begin
				cur_pixel = pixel_q.pop_front();
				cmd <= cur_pixel.cmd;
				row <= cur_pixel.row;
				col <= cur_pixel.col;
				pixel_time <= cur_pixel.ptime;
				grad_x <= cur_pixel.gx;
				grad_y <= cur_pixel.gy;
				last <= cur_pixel.last;
				nv = 1'b1;
				in_gap = pick_gap();
			end
		end
		valid_in <= nv;
	end

	task automatic check_field(input string name, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	// monitor: compare each result transfer against the oldest expectation
	int unsigned out_stall = 0;
	always @(posedge clk) begin : result_monitor
		moments_t e;
		if (valid_out && ready_in) begin
			if (moments_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, kind %0d status %0d count %0d",
					$time, kind, status, count);
			end else begin
				e = moments_q.pop_front();
				check_field("kind", e.kind, kind);
				check_field("status", e.status, status);
				check_field("count", e.count, count);
				check_field("center_row", e.crow, center_row);
				check_field("center_col", e.ccol, center_col);
				check_field("mean_grad_x", e.mgx, longint'(mean_grad_x));
				check_field("mean_grad_y", e.mgy, longint'(mean_grad_y));
				check_field("rotation", e.rot, longint'(rotation));
				check_field("divergence", e.dvg, longint'(divergence));
			end
			out_stall = pick_gap();
		end
		if (!arst_n) begin
			ready_in <= 1'b0;
		end else if (out_stall > 0) begin
			out_stall--;
			ready_in <= 1'b0;
		end else begin
			ready_in <= 1'b1;
		end
	end

	// watchdog: end the run after too long without any transfer
	int unsigned quiet_cycles = 0;
	always @(posedge clk) begin
		if ((valid_in && ready_out) || (valid_out && ready_in) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("** flow_field_moments_top: FAILED **");
			$finish;
		end
	end

	task automatic push_pixel(input logic c, input logic [9:0] r, input logic [9:0] k,
		input logic [15:0] t, input logic [15:0] gx, input logic [15:0] gy, input logic l);
		while (pixel_q.size() >= 64)
			@(posedge clk);
		pixel_q.push_back('{c, r, k, t, gx, gy, l});
		items_sent++;
	endtask

	// wait until every pixel is transferred and every result is back
	task automatic drain();
		while (pixel_q.size() > 0 || valid_in || moments_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		thr_shadow = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_time();
		int t;
		if ($urandom_range(0, 1))
			return 16'($urandom_range(0, 65535));
		t = int'(thr_shadow) + int'($urandom_range(0, 6)) - 3;
		if (t < 0)
			t = 0;
		if (t > 65535)
			t = 65535;
		return 16'(t);
	endfunction

	function automatic logic [9:0] pick_pos();
		case ($urandom_range(0, 5))
			0: return 10'd0;
			1: return 10'd1023;
			default: return 10'($urandom_range(0, 1023));
		endcase
	endfunction

	// one pass of random pixels; most passes keep one kind, a few mix them
	task automatic random_pass();
		int unsigned len, i;
		logic pc, c;
		bit mixed;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
		pc = 1'($urandom_range(0, 1));
		mixed = ($urandom_range(0, 9) == 0);
		quiet_mode = ($urandom_range(0, 3) == 0);
		for (i = 0; i < len; i++) begin
			c = mixed ? 1'($urandom_range(0, 1)) : pc;
			if ($urandom_range(0, 19) == 0)
				c = ~pc;
			push_pixel(i == len - 1 ? pc : c, pick_pos(), pick_pos(), pick_time(),
				16'($urandom), 16'($urandom), i == len - 1);
		end
	endtask

	initial begin
		logic [15:0] thresholds[6];
		int unsigned ph;
		thresholds = '{16'd0, 16'd65535, 16'd1, 16'h8000, 16'd0, 16'd0};
		thresholds[4] = 16'($urandom_range(2, 65534));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty passes, position and gradient extremes, mixed pass
		push_pixel(ffm_pkg::CMD_CENTROID, 10'd5, 10'd5, 16'd0, 16'h0, 16'h0, 1'b1);
		push_pixel(ffm_pkg::CMD_MOTION, 10'd5, 10'd5, 16'd0, 16'h7FFF, 16'h8000, 1'b1);
		push_pixel(ffm_pkg::CMD_CENTROID, 10'd0, 10'd0, 16'd1, 16'h0, 16'h0, 1'b0);
		push_pixel(ffm_pkg::CMD_CENTROID, 10'd1023, 10'd1023, 16'hFFFF, 16'h0, 16'h0, 1'b0);
		push_pixel(ffm_pkg::CMD_CENTROID, 10'd1023, 10'd0, 16'd0, 16'h0, 16'h0, 1'b1);
		push_pixel(ffm_pkg::CMD_MOTION, 10'd0, 10'd1023, 16'hFFFF, 16'h8000, 16'h8000, 1'b0);
		push_pixel(ffm_pkg::CMD_MOTION, 10'd1023, 10'd0, 16'hFFFF, 16'h7FFF, 16'h7FFF, 1'b0);
		push_pixel(ffm_pkg::CMD_MOTION, 10'd0, 10'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b1);
		push_pixel(ffm_pkg::CMD_MOTION, 10'd3, 10'd9, 16'h10, 16'hFFFF, 16'h0001, 1'b1);
		push_pixel(ffm_pkg::CMD_CENTROID, 10'd512, 10'd300, 16'h1, 16'h0, 16'h0, 1'b0);
		push_pixel(ffm_pkg::CMD_MOTION, 10'd100, 10'd900, 16'h1, 16'hFFF3, 16'h0021, 1'b0);
		push_pixel(ffm_pkg::CMD_CENTROID, 10'd700, 10'd20, 16'h2, 16'h0, 16'h0, 1'b1);
		push_pixel(ffm_pkg::CMD_MOTION, 10'd1, 10'd2, 16'h3, 16'h5555, 16'hAAAA, 1'b0);
		push_pixel(ffm_pkg::CMD_CENTROID, 10'd7, 10'd8, 16'h4, 16'h0, 16'h0, 1'b0);
		push_pixel(ffm_pkg::CMD_MOTION, 10'd9, 10'd1000, 16'h5, 16'hAAAA, 16'h5555, 1'b1);
		drain();

		// random passes under several thresholds, extremes included
		for (ph = 0; ph < 6; ph++) begin
			write_threshold(thresholds[ph]);
			while (items_sent < (ph + 1) * (ITEM_TARGET / 6) + 15)
				random_pass();
			drain();
		end

		if (errors == 0 && moments_q.size() == 0) begin
			$display("** flow_field_moments_top: PASSED **");
		end else begin
			$display("** flow_field_moments_top: FAILED **");
		end
		$finish;
	end

endmodule

// File: sim.f
src/ffm_pkg.sv
src/ffm_front.sv
src/ffm_div.sv
src/ffm_back.sv
src/flow_field_moments_top.sv
src/ffm_checker.sv
dv/flow_field_moments_top_test.sv
